>>> rtl/lsim_pkg.sv
// Package for the LoRA segment index mapper.
// Holds sizes, field codes and shared types. No dependencies.
package lsim_pkg;

    localparam int MAX_EXPERTS = 256;
    localparam int MAX_LORAS   = 64;
    localparam int ROW_BITS    = 16;

    localparam int Q_AW      = $clog2(MAX_EXPERTS);
    localparam int PTR_W     = Q_AW + 1;
    localparam int EXP_W     = 8;
    localparam int ENTRY_W   = ROW_BITS + EXP_W;
    localparam int SLOT_W    = $clog2(MAX_LORAS);
    localparam int IDX_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_ROW   = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SLOT_BAD = 3'd1;
    localparam logic [2:0] ST_DISABLED = 3'd2;
    localparam logic [2:0] ST_TAIL     = 3'd3;
    localparam logic [2:0] ST_EXCESS   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_EXPERTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LORAS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK        = 2'd3;

    typedef struct packed {
        logic              bad;
        logic [SLOT_W-1:0] slot;
    } t_slot_res;

endpackage

>>> rtl/lsim_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module lsim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/lsim_slot_dec.sv
// Float32 slot decoder: truncates a slot value toward zero and flags bad slots.
// Depends on lsim_pkg.
module lsim_slot_dec (
    input  logic [31:0]               i_slot_bits,
    input  logic [6:0]                i_num_loras,
    output lsim_pkg::t_slot_res       o_res
);
    import lsim_pkg::*;

    logic       sign;
    logic [7:0] expo;
    logic       mag_zero;
    logic       too_big;
    logic [2:0] shamt;
    logic [6:0] ival;

    always_comb begin
        sign     = i_slot_bits[31];
        expo     = i_slot_bits[30:23];
        mag_zero = (i_slot_bits[30:0] == 31'd0);
        too_big  = (expo >= 8'd134);
        shamt    = 3'd6 - 3'(expo - 8'd127);
        if (expo < 8'd127) begin
            ival = 7'd0;
        end else if (too_big) begin
            ival = 7'd0;
        end else begin
            ival = {1'b1, i_slot_bits[22:17]} >> shamt;
        end
        o_res.bad  = (sign && !mag_zero) || too_big || (ival >= i_num_loras)
                   || (ival >= 7'(MAX_LORAS));
        o_res.slot = ival[SLOT_W-1:0];
    end
endmodule

>>> rtl/moe_lora_segment_index_mapper.sv
// LoRA segment index mapper top level: input register, segment queue, result register.
// Depends on lsim_pkg, lsim_ram and lsim_slot_dec.
// The block takes one item per cycle unless a row item waits on a full result register.
// A row result passes the input and result registers; a count item gives no result. The
// segment queue sits in a 256-entry RAM whose head is held in a register while the next
// entry is read ahead, so a row moves at most one segment forward and never waits on memory.
module moe_lora_segment_index_mapper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsim_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                        i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic signed [31:0]                 i_group_count,
    input  logic [31:0]                        i_slot_bits,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [lsim_pkg::IDX_W-1:0]  o_bgmv_index,
    output logic [lsim_pkg::EXP_W-1:0]         o_owner_expert,
    output logic [2:0]                         o_status
);
    import lsim_pkg::*;

    logic [15:0] r_num_rows;
    logic [8:0]  r_num_experts;
    logic [6:0]  r_num_loras;
    logic [63:0] r_mask;

    logic        r_in_valid;
    logic        r_in_op;
    logic [31:0] r_in_count;
    logic [31:0] r_in_slot;

    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_index;
    logic [EXP_W-1:0]     r_out_expert;
    logic [2:0]           r_out_status;

    logic [PTR_W-1:0]    r_wp, r_rp, r_loaded;
    logic [ROW_BITS-1:0] r_run_end, r_row;
    logic                r_phase;
    logic [ENTRY_W-1:0]  r_cur;
    logic                r_byp_hit;
    logic [ENTRY_W-1:0]  r_byp_data;

    logic [PTR_W-1:0]    n_wp, n_rp, n_loaded;
    logic [ROW_BITS-1:0] n_run_end, n_row;
    logic                n_phase;
    logic [ENTRY_W-1:0]  n_cur;

    logic               can_out, proc, proc_cnt, proc_row;
    logic [ENTRY_W-1:0] ram_rdata, rd_entry, wr_entry;
    logic [Q_AW-1:0]    raddr;
    logic               we;

    logic [PTR_W-1:0]    ld_wp, ld_loaded, exp_lim;
    logic [ROW_BITS-1:0] ld_run, sum_sat;
    logic [31:0]         sum;
    logic                ld_take, grow;

    logic              head_valid, next_valid, excess, adv, own_valid;
    logic [EXP_W-1:0]  own_exp;
    logic [IDX_W-1:0]  mul_idx;
    t_slot_res         slot_res;

    assign can_out    = !r_out_valid || i_out_ready;
    assign proc       = r_in_valid && ((r_in_op == OP_COUNT) || can_out);
    assign proc_cnt   = proc && (r_in_op == OP_COUNT);
    assign proc_row   = proc && (r_in_op == OP_ROW);
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows    <= '0;
            r_num_experts <= 9'd1;
            r_num_loras   <= 7'd1;
            r_mask        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_ROWS:    r_num_rows    <= i_cfg_wdata[15:0];
                CFG_NUM_EXPERTS: r_num_experts <= i_cfg_wdata[8:0];
                CFG_NUM_LORAS:   r_num_loras   <= i_cfg_wdata[6:0];
                CFG_MASK:        r_mask        <= i_cfg_wdata;
                default:         r_mask        <= r_mask;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_op    <= i_op;
            r_in_count <= i_group_count;
            r_in_slot  <= i_slot_bits;
        end
    end

    lsim_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_EXPERTS)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(ld_wp[Q_AW-1:0]),
        .i_wdata(wr_entry),
        .i_raddr(raddr),
        .o_rdata(ram_rdata)
    );

    lsim_slot_dec u_slot (
        .i_slot_bits(r_in_slot),
        .i_num_loras(r_num_loras),
        .o_res      (slot_res)
    );

    assign rd_entry = r_byp_hit ? r_byp_data : ram_rdata;

    always_comb begin
        ld_wp     = r_phase ? '0 : r_wp;
        ld_run    = r_phase ? '0 : r_run_end;
        ld_loaded = r_phase ? '0 : r_loaded;
        if (r_num_experts == 9'd0) begin
            exp_lim = PTR_W'(1);
        end else if (32'(r_num_experts) > 32'(MAX_EXPERTS)) begin
            exp_lim = PTR_W'(MAX_EXPERTS);
        end else begin
            exp_lim = PTR_W'(r_num_experts);
        end
        ld_take = ld_loaded < exp_lim;
        if (!r_in_count[31] && (r_in_count != 32'd0)) begin
            sum = 32'(ld_run) + {1'b0, r_in_count[30:0]};
        end else begin
            sum = 32'(ld_run);
        end
        sum_sat  = (sum > 32'(r_num_rows)) ? r_num_rows : sum[ROW_BITS-1:0];
        grow     = sum_sat > ld_run;
        we       = proc_cnt && ld_take && grow && !ld_wp[PTR_W-1];
        wr_entry = {ld_loaded[EXP_W-1:0], sum_sat};

        head_valid = r_rp < r_wp;
        next_valid = (PTR_W + 1)'(r_rp) + 1'b1 < (PTR_W + 1)'(r_wp);
        excess     = r_row >= r_num_rows;
        adv        = head_valid && (r_cur[ROW_BITS-1:0] <= r_row);
        own_valid  = adv ? next_valid : head_valid;
        own_exp    = adv ? rd_entry[ENTRY_W-1:ROW_BITS] : r_cur[ENTRY_W-1:ROW_BITS];
        mul_idx    = IDX_W'(slot_res.slot * r_num_experts + 17'(own_exp));

        n_wp      = r_wp;
        n_rp      = r_rp;
        n_loaded  = r_loaded;
        n_run_end = r_run_end;
        n_row     = r_row;
        n_phase   = r_phase;
        n_cur     = r_cur;
        if (proc_cnt) begin
            n_phase   = 1'b0;
            n_row     = '0;
            n_rp      = '0;
            n_wp      = ld_wp + PTR_W'(we);
            n_loaded  = ld_loaded + PTR_W'(ld_take);
            n_run_end = (ld_take && grow) ? sum_sat : ld_run;
            if (we && (ld_wp == '0)) begin
                n_cur = wr_entry;
            end
        end else if (proc_row) begin
            n_phase = 1'b1;
            if (!excess) begin
                n_row = r_row + 1'b1;
                if (adv) begin
                    n_rp  = r_rp + 1'b1;
                    n_cur = rd_entry;
                end
            end
        end
        raddr = Q_AW'(n_rp + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_loaded  <= '0;
            r_run_end <= '0;
            r_row     <= '0;
            r_phase   <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_loaded  <= n_loaded;
            r_run_end <= n_run_end;
            r_row     <= n_row;
            r_phase   <= n_phase;
            r_byp_hit <= we && (ld_wp[Q_AW-1:0] == raddr);
        end
        r_cur      <= n_cur;
        r_byp_data <= wr_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_out) begin
            r_out_valid <= proc_row;
        end
        if (proc_row) begin
            r_out_index  <= '1;
            r_out_expert <= '0;
            priority if (excess) begin
                r_out_status <= ST_EXCESS;
            end else if (!own_valid) begin
                r_out_status <= ST_TAIL;
            end else if (slot_res.bad) begin
                r_out_status <= ST_SLOT_BAD;
                r_out_expert <= own_exp;
            end else if (!r_mask[slot_res.slot]) begin
                r_out_status <= ST_DISABLED;
                r_out_expert <= own_exp;
            end else begin
                r_out_status <= ST_OK;
                r_out_expert <= own_exp;
                r_out_index  <= mul_idx;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bgmv_index   = r_out_index;
    assign o_owner_expert = r_out_expert;
    assign o_status       = r_out_status;

    a_rp_le_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_wp)
        else $error("Queue read pointer passed the write pointer.");

    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_index == '1))
        else $error("Failed row item carries an index.");

    a_wp_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase && !proc_cnt) |=> $stable(r_wp))
        else $error("Queue written during the row phase.");

    a_tail_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_status == ST_TAIL) || (r_out_status == ST_EXCESS)))
            |-> (r_out_expert == '0))
        else $error("Tail or excess row item names an expert.");
endmodule
